/* sv/tlsr_pkg.sv */
// Shared constants and types for the thick line stamp rasterizer.
package tlsr_pkg;

   localparam int COORD_W = 11;
   localparam int BRUSH_W = 6;
   localparam int INK_W   = 32;

   // Screen size in pixels; stamps are clipped against these edges.
   localparam int SCREEN_W = 1024;
   localparam int SCREEN_H = 600;

   localparam logic [BRUSH_W-1:0] BRUSH_RESET = BRUSH_W'(20);

   // One quotient bit is produced per divider iteration.
   localparam int DIV_STEPS = COORD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } opcode_type;

endpackage

/* sv/thick_line_stamp_rasterizer.sv */
// Top level: segment store, stamp sequencer and shared restoring divider.
//
//  channel | ports   | handshake     | moves
//  --------+---------+---------------+------------------------------------
//  request | req_*   | valid / stall | load segment or step to next stamp
//  result  | rsp_*   | valid / stall | one clipped stamp per step
//  config  | csr_*   | valid / ready | brush size register
//
// A load transaction gives no result. A step passes in order through accepting,
// the 11 by 11 magnitude multiply, the shared radix-2 divider (one quotient
// bit per iteration), adding the minor start, and clipping and filling the
// output register.
// The output register waits for rsp_stall to drop; while it holds a stamp the
// next transaction is still accepted. Reset is synchronous, active high.
module thick_line_stamp_rasterizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [tlsr_pkg::COORD_W-1:0]  req_x_start,
   input  logic [tlsr_pkg::COORD_W-1:0]  req_y_start,
   input  logic [tlsr_pkg::COORD_W-1:0]  req_x_end,
   input  logic [tlsr_pkg::COORD_W-1:0]  req_y_end,
   input  logic [tlsr_pkg::INK_W-1:0]    req_ink,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tlsr_pkg::COORD_W-1:0]  rsp_rect_x,
   output logic [tlsr_pkg::COORD_W-1:0]  rsp_rect_y,
   output logic [tlsr_pkg::BRUSH_W-1:0]  rsp_rect_w,
   output logic [tlsr_pkg::BRUSH_W-1:0]  rsp_rect_h,
   output logic [tlsr_pkg::INK_W-1:0]    rsp_stamp_ink,
   output logic                          rsp_visible,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tlsr_pkg::BRUSH_W-1:0]  csr_brush_size
);

   localparam int CW = tlsr_pkg::COORD_W;
   localparam int BW = tlsr_pkg::BRUSH_W;
   localparam int IW = tlsr_pkg::INK_W;
   localparam int SW = CW + 1;
   localparam int LW = CW + 2;
   localparam int NW = 2 * CW;
   localparam int KW = tlsr_pkg::CNT_W;

   localparam logic [LW-1:0] SCREEN_W_L = LW'(tlsr_pkg::SCREEN_W);
   localparam logic [LW-1:0] SCREEN_H_L = LW'(tlsr_pkg::SCREEN_H);
   localparam logic [KW-1:0] LAST_STEP  = KW'(tlsr_pkg::DIV_STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [BW-1:0]     brush_ff, brush_in;
   logic [CW-1:0]     seg_x0_ff, seg_x0_in, seg_y0_ff, seg_y0_in;
   logic [CW-1:0]     seg_x1_ff, seg_x1_in, seg_y1_ff, seg_y1_in;
   logic [IW-1:0]     seg_ink_ff, seg_ink_in;
   logic              major_is_y_ff, major_is_y_in;
   logic [CW-1:0]     major_pos_ff, major_pos_in;
   logic              active_ff, active_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [CW-1:0]     low_ff, low_in;
   logic [CW-1:0]     den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [KW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     x_ff, x_in, y_ff, y_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]     rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [BW-1:0]     rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;
   logic [IW-1:0]     rsp_ink_ff, rsp_ink_in;
   logic              rsp_vis_ff, rsp_vis_in;
   logic              rsp_last_ff, rsp_last_in;

   // Load decode.
   logic signed [SW-1:0] ld_dx, ld_dy;
   logic [CW-1:0]        ld_adx, ld_ady;
   logic                 ld_major_y;

   // Operands of the current segment, ordered major then minor.
   logic [CW-1:0]        s_maj, e_maj, s_min, e_min;
   logic signed [SW-1:0] d_pos, d_min, d_maj;
   logic [CW-1:0]        m_pos, m_min, m_maj;
   logic [NW-1:0]        prod;

   // Divider step, minor coordinate and clipping.
   logic [SW-1:0]        trial;
   logic                 q_bit;
   logic [CW-1:0]        quot;
   logic [SW-1:0]        q_signed, minor_sum;
   logic signed [LW-1:0] lim_w, lim_h, brush_l, w_clip, h_clip;
   logic                 vis;
   logic                 slot_free;

   always_comb begin
      ld_dx      = $signed({1'b0, req_x_end}) - $signed({1'b0, req_x_start});
      ld_dy      = $signed({1'b0, req_y_end}) - $signed({1'b0, req_y_start});
      ld_adx     = ld_dx[SW-1] ? CW'(-ld_dx) : ld_dx[CW-1:0];
      ld_ady     = ld_dy[SW-1] ? CW'(-ld_dy) : ld_dy[CW-1:0];
      ld_major_y = (ld_dx == '0) || (ld_ady > ld_adx);

      s_maj = major_is_y_ff ? seg_y0_ff : seg_x0_ff;
      e_maj = major_is_y_ff ? seg_y1_ff : seg_x1_ff;
      s_min = major_is_y_ff ? seg_x0_ff : seg_y0_ff;
      e_min = major_is_y_ff ? seg_x1_ff : seg_y1_ff;
      d_pos = $signed({1'b0, major_pos_ff}) - $signed({1'b0, s_maj});
      d_min = $signed({1'b0, e_min}) - $signed({1'b0, s_min});
      d_maj = $signed({1'b0, e_maj}) - $signed({1'b0, s_maj});
      m_pos = d_pos[SW-1] ? CW'(-d_pos) : d_pos[CW-1:0];
      m_min = d_min[SW-1] ? CW'(-d_min) : d_min[CW-1:0];
      m_maj = d_maj[SW-1] ? CW'(-d_maj) : d_maj[CW-1:0];
      prod  = NW'(m_pos) * NW'(m_min);

      trial = {rem_ff, low_ff[CW-1]};
      q_bit = trial >= {1'b0, den_ff};

      // A zero major span only occurs on a single point, whose offset is zero.
      quot      = (den_ff == '0) ? '0 : low_ff;
      q_signed  = neg_ff ? SW'(-{1'b0, quot}) : {1'b0, quot};
      minor_sum = {1'b0, s_min} + q_signed;

      brush_l = $signed(LW'(brush_ff));
      lim_w   = $signed(SCREEN_W_L - LW'(x_ff));
      lim_h   = $signed(SCREEN_H_L - LW'(y_ff));
      w_clip  = (brush_l > lim_w) ? lim_w : brush_l;
      h_clip  = (brush_l > lim_h) ? lim_h : brush_l;
      vis     = (w_clip > 0) && (h_clip > 0);

      slot_free = !rsp_valid_ff || !rsp_stall;

      state_in      = state_ff;
      brush_in      = brush_ff;
      seg_x0_in     = seg_x0_ff;
      seg_y0_in     = seg_y0_ff;
      seg_x1_in     = seg_x1_ff;
      seg_y1_in     = seg_y1_ff;
      seg_ink_in    = seg_ink_ff;
      major_is_y_in = major_is_y_ff;
      major_pos_in  = major_pos_ff;
      active_in     = active_ff;
      rem_in        = rem_ff;
      low_in        = low_ff;
      den_in        = den_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_h_in      = rsp_h_ff;
      rsp_ink_in    = rsp_ink_ff;
      rsp_vis_in    = rsp_vis_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               brush_in = csr_brush_size;
            end
            if (req_valid) begin
               if (req_opcode == tlsr_pkg::OP_LOAD) begin
                  seg_x0_in     = req_x_start;
                  seg_y0_in     = req_y_start;
                  seg_x1_in     = req_x_end;
                  seg_y1_in     = req_y_end;
                  seg_ink_in    = req_ink;
                  major_is_y_in = ld_major_y;
                  major_pos_in  = ld_major_y ? req_y_start : req_x_start;
                  active_in     = 1'b1;
               end else if (active_ff) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // The magnitude product is below den * 2^11, so the upper half
            // already starts below the divisor.
            rem_in   = prod[NW-1:CW];
            low_in   = prod[CW-1:0];
            den_in   = m_maj;
            neg_in   = d_pos[SW-1] ^ d_min[SW-1] ^ d_maj[SW-1];
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = q_bit ? CW'(trial - {1'b0, den_ff}) : trial[CW-1:0];
            low_in = {low_ff[CW-2:0], q_bit};
            cnt_in = cnt_ff + KW'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            x_in     = major_is_y_ff ? minor_sum[CW-1:0] : major_pos_ff;
            y_in     = major_is_y_ff ? major_pos_ff : minor_sum[CW-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_ff;
               rsp_y_in     = y_ff;
               rsp_w_in     = vis ? w_clip[BW-1:0] : '0;
               rsp_h_in     = vis ? h_clip[BW-1:0] : '0;
               rsp_ink_in   = seg_ink_ff;
               rsp_vis_in   = vis;
               rsp_last_in  = (major_pos_ff == e_maj);
               if (major_pos_ff == e_maj) begin
                  active_in = 1'b0;
               end else if (e_maj > s_maj) begin
                  major_pos_in = major_pos_ff + CW'(1);
               end else begin
                  major_pos_in = major_pos_ff - CW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         brush_ff      <= tlsr_pkg::BRUSH_RESET;
         seg_x0_ff     <= '0;
         seg_y0_ff     <= '0;
         seg_x1_ff     <= '0;
         seg_y1_ff     <= '0;
         seg_ink_ff    <= '0;
         major_is_y_ff <= 1'b0;
         major_pos_ff  <= '0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         brush_ff      <= brush_in;
         seg_x0_ff     <= seg_x0_in;
         seg_y0_ff     <= seg_y0_in;
         seg_x1_ff     <= seg_x1_in;
         seg_y1_ff     <= seg_y1_in;
         seg_ink_ff    <= seg_ink_in;
         major_is_y_ff <= major_is_y_in;
         major_pos_ff  <= major_pos_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_w_ff    <= rsp_w_in;
      rsp_h_ff    <= rsp_h_in;
      rsp_ink_ff  <= rsp_ink_in;
      rsp_vis_ff  <= rsp_vis_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rect_x    = rsp_x_ff;
   assign rsp_rect_y    = rsp_y_ff;
   assign rsp_rect_w    = rsp_w_ff;
   assign rsp_rect_h    = rsp_h_ff;
   assign rsp_stamp_ink = rsp_ink_ff;
   assign rsp_visible   = rsp_vis_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
